// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every edge while the disable term is low.
`define ASSERT_ALWAYS(label, clk, dis, cond) \
   label: assert property (@(posedge clk) disable iff (dis) (cond)) \
      else $error("assertion failed");

// The consequent follows the antecedent as a non-overlapping implication.
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/mme_pkg.sv =====
package mme_pkg;

   localparam int IDX_W     = 3;
   localparam int VAL_W     = 16;
   localparam int PROD_W    = 32;
   localparam int ACC_W     = 35;
   localparam int RES_W     = 32;
   localparam int SIZE_W    = 4;
   localparam int CMD_W     = 2;
   localparam int CSR_IDX_W = 2;

   localparam int CQ_DEPTH  = 2;
   localparam int CQ_PTR_W  = 1;
   localparam int CQ_CNT_W  = 2;

   localparam int RES_DEPTH = 4;
   localparam int RES_PTR_W = 2;
   localparam int RES_CNT_W = 3;

   localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_A_ROWS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B_COLS     = 2'd2;

   typedef enum logic [1:0] {
      OP_WRITE_A = 2'd0,
      OP_WRITE_B = 2'd1,
      OP_COMPUTE = 2'd2
   } op_type;

   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic [IDX_W-1:0]        row_index;
      logic [IDX_W-1:0]        col_index;
      logic signed [VAL_W-1:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_row;
      logic [IDX_W-1:0]        out_col;
      logic signed [RES_W-1:0] result_value;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      op_type                  op;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic [SIZE_W-1:0] m;
      logic [SIZE_W-1:0] n;
      logic [SIZE_W-1:0] p;
   } size_type;

   typedef struct packed {
      logic                 busy;
      logic [RES_CNT_W-1:0] res_count;
   } back_status_type;

endpackage

// ===== hw/rtl/mme_front.sv =====
module mme_front import mme_pkg::*; #(
   parameter int MAX_DIM = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    cq_valid,
   output cmd_type cq_head,
   input  logic    cq_pop
);

   localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;

   cmd_type              entry_ff [CQ_DEPTH];
   logic [CQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CQ_CNT_W-1:0]  count_ff, count_in;
   logic                 accept;
   logic                 keep;
   logic                 in_range;
   op_type               op;
   logic                 push;
   logic                 pop;

   assign in_range = ({1'b0, req_data.row_index} < SIZE_W'(DIM_CAP)) &&
                     ({1'b0, req_data.col_index} < SIZE_W'(DIM_CAP));

   // Writes outside the stores and the unused code are taken and dropped here.
   always_comb begin
      keep = 1'b0;
      op   = OP_COMPUTE;
      unique case (req_data.cmd) inside
         CMD_WRITE_A, CMD_WRITE_B: begin
            keep = in_range;
            op   = (req_data.cmd == CMD_WRITE_A) ? OP_WRITE_A : OP_WRITE_B;
         end
         CMD_COMPUTE: begin
            keep = 1'b1;
            op   = OP_COMPUTE;
         end
         default: begin
            keep = 1'b0;
            op   = OP_COMPUTE;
         end
      endcase
   end

   assign req_full = (count_ff == CQ_CNT_W'(CQ_DEPTH));
   assign accept   = req_push && !req_full;
   assign push     = accept && keep;
   assign cq_valid = (count_ff != '0);
   assign pop      = cq_pop && cq_valid;
   assign cq_head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CQ_CNT_W'(push) - CQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{op: op, row: req_data.row_index,
                                  col: req_data.col_index, value: req_data.entry_value};
      end
   end

endmodule

// ===== hw/rtl/mme_back.sv =====
module mme_back import mme_pkg::*; #(
   parameter int MAX_DIM = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            cq_valid,
   input  cmd_type         cq_head,
   output logic            cq_pop,
   input  size_type        sizes,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output rsp_type         rsp_data,
   output back_status_type status
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DRAIN = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;

   logic signed [VAL_W-1:0] mem_a [DEPTH];
   logic signed [VAL_W-1:0] mem_b [DEPTH];

   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic             i_last, j_last, k_last;
   logic             advance;
   logic             issue;
   logic             wr_a, wr_b;
   logic [ADDR_W-1:0] wr_addr, a_rd_addr, b_rd_addr;

   // Stage one: store read data and tags.
   logic                    s1_valid_ff;
   logic                    s1_first_ff, s1_lastk_ff, s1_lastent_ff;
   logic [IDX_W-1:0]        s1_i_ff, s1_j_ff;
   logic signed [VAL_W-1:0] a_rd_ff, b_rd_ff;

   // Stage two: product and tags.
   logic                     s2_valid_ff;
   logic                     s2_first_ff, s2_lastk_ff, s2_lastent_ff;
   logic [IDX_W-1:0]         s2_i_ff, s2_j_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [RES_W-1:0] sat_value;

   rsp_type               res_mem [RES_DEPTH];
   logic [RES_PTR_W-1:0]  res_wr_ff, res_rd_ff;
   logic [RES_CNT_W-1:0]  res_count_ff, res_count_in;
   logic                  res_full;
   logic                  res_push;
   logic                  res_pop;

   assign res_full  = (res_count_ff == RES_CNT_W'(RES_DEPTH));
   assign advance   = !res_full;
   assign issue     = (state_ff == ST_ISSUE) && advance;

   assign k_last = ({1'b0, k_ff} == sizes.n - 4'd1);
   assign j_last = ({1'b0, j_ff} == sizes.p - 4'd1);
   assign i_last = ({1'b0, i_ff} == sizes.m - 4'd1);

   assign wr_addr   = ADDR_W'(cq_head.row) * ADDR_W'(MAX_DIM) + ADDR_W'(cq_head.col);
   assign a_rd_addr = ADDR_W'(i_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(k_ff);
   assign b_rd_addr = ADDR_W'(k_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(j_ff);

   assign wr_a = cq_pop && (cq_head.op == OP_WRITE_A);
   assign wr_b = cq_pop && (cq_head.op == OP_WRITE_B);

   always_comb begin
      state_in = state_ff;
      cq_pop   = 1'b0;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cq_valid) begin
               cq_pop = 1'b1;
               if (cq_head.op == OP_COMPUTE) begin
                  state_in = ST_ISSUE;
                  i_in     = '0;
                  j_in     = '0;
                  k_in     = '0;
               end
            end
         end
         ST_ISSUE: begin
            if (advance) begin
               if (!k_last) begin
                  k_in = k_ff + 1'b1;
               end else begin
                  k_in = '0;
                  if (!j_last) begin
                     j_in = j_ff + 1'b1;
                  end else begin
                     j_in = '0;
                     if (!i_last) begin
                        i_in = i_ff + 1'b1;
                     end else begin
                        state_in = ST_DRAIN;
                     end
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (advance) begin
            s1_valid_ff <= issue;
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      if (advance) begin
         s1_first_ff   <= (k_ff == '0);
         s1_lastk_ff   <= k_last;
         s1_lastent_ff <= i_last && j_last;
         s1_i_ff       <= i_ff;
         s1_j_ff       <= j_ff;
         s2_first_ff   <= s1_first_ff;
         s2_lastk_ff   <= s1_lastk_ff;
         s2_lastent_ff <= s1_lastent_ff;
         s2_i_ff       <= s1_i_ff;
         s2_j_ff       <= s1_j_ff;
         prod_ff       <= a_rd_ff * b_rd_ff;
      end
      if (advance && s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[wr_addr] <= cq_head.value;
      end
      if (issue) begin
         a_rd_ff <= mem_a[a_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[wr_addr] <= cq_head.value;
      end
      if (issue) begin
         b_rd_ff <= mem_b[b_rd_addr];
      end
   end

   // The first term of a dot product restarts the sum.
   always_comb begin
      acc_in = (s2_first_ff ? ACC_W'(0) : acc_ff) +
               {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      if (acc_in[ACC_W-1:RES_W-1] == '0 || acc_in[ACC_W-1:RES_W-1] == '1) begin
         sat_value = acc_in[RES_W-1:0];
      end else if (acc_in[ACC_W-1]) begin
         sat_value = {1'b1, {(RES_W - 1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(RES_W - 1){1'b1}}};
      end
   end

   assign res_push  = advance && s2_valid_ff && s2_lastk_ff;
   assign rsp_empty = (res_count_ff == '0);
   assign res_pop   = rsp_pop && !rsp_empty;
   assign rsp_data  = res_mem[res_rd_ff];
   assign res_count_in = res_count_ff + RES_CNT_W'(res_push) - RES_CNT_W'(res_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         res_wr_ff    <= '0;
         res_rd_ff    <= '0;
         res_count_ff <= '0;
      end else begin
         if (res_push) begin
            res_wr_ff <= res_wr_ff + 1'b1;
         end
         if (res_pop) begin
            res_rd_ff <= res_rd_ff + 1'b1;
         end
         res_count_ff <= res_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         res_mem[res_wr_ff] <= '{out_row: s2_i_ff, out_col: s2_j_ff,
                                 result_value: sat_value, last: s2_lastent_ff};
      end
   end

   assign status.busy      = (state_ff != ST_IDLE) || s1_valid_ff || s2_valid_ff;
   assign status.res_count = res_count_ff;

endmodule

// ===== hw/rtl/matrix_multiply_engine_unit.sv =====
// Channel   Handshake          Payload
// req       req_push/req_full  req_data (cmd, row_index, col_index, entry_value)
// rsp       rsp_pop/rsp_empty  rsp_data (out_row, out_col, result_value, last)
// csr       csr_valid/ready    csr_index, csr_wdata (ready is always high)
//
// A load word waits in the command queue until the idle engine pops it and writes its store.
// A compute word steps through m*p*n products on the single multiply-accumulate unit,
// then drains its three-stage read, multiply and sum pipeline.
// Synchronous reset empties both queues; the stores are not cleared.
// The pipeline stalls while the four-word result queue is full.
`include "assert_macros.svh"

module matrix_multiply_engine_unit import mme_pkg::*; #(
   parameter int MAX_DIM = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_type              req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_wdata
);

   localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;

   size_type          sizes_ff;
   logic [SIZE_W-1:0] clamped;
   logic              csr_write;
   logic              cq_valid;
   cmd_type           cq_head;
   logic              cq_pop;
   back_status_type   status;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Sizes are held already clamped into one to the index limit.
   always_comb begin
      if (csr_wdata == '0) begin
         clamped = SIZE_W'(1);
      end else if (csr_wdata > SIZE_W'(DIM_CAP)) begin
         clamped = SIZE_W'(DIM_CAP);
      end else begin
         clamped = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sizes_ff.m <= SIZE_W'(DIM_CAP);
         sizes_ff.n <= SIZE_W'(DIM_CAP);
         sizes_ff.p <= SIZE_W'(DIM_CAP);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_A_ROWS:     sizes_ff.m <= clamped;
            CSR_INNER_SIZE: sizes_ff.n <= clamped;
            CSR_B_COLS:     sizes_ff.p <= clamped;
            default: begin
            end
         endcase
      end
   end

   mme_front #(.MAX_DIM(MAX_DIM)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cq_valid (cq_valid),
      .cq_head  (cq_head),
      .cq_pop   (cq_pop)
   );

   mme_back #(.MAX_DIM(MAX_DIM)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cq_valid  (cq_valid),
      .cq_head   (cq_head),
      .cq_pop    (cq_pop),
      .sizes     (sizes_ff),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .status    (status)
   );

   `ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, rsp_empty)
   `ASSERT_ALWAYS(a_res_count_bound, clock, reset, status.res_count <= RES_CNT_W'(RES_DEPTH))
   `ASSERT_NEXT(a_idle_no_result, clock, reset, !status.busy && rsp_empty, rsp_empty)

endmodule
